@@ hw/rtl/ld_pkg.sv @@
// Shared constants for the Leibniz determinant core.
package ld_pkg;

    localparam int MAX_ORDER_DEF = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int ORDER_W       = 3;
    localparam int MAG_W         = 54;
    localparam int ACC_W         = 64;
    localparam int PADDR_W       = 3;

    localparam logic [0:0] REG_MATRIX_ORDER = 1'b0;

endpackage

@@ hw/rtl/ld_store.sv @@
// Element store: one write port, one registered read port.
module ld_store
    import ld_pkg::*;
#(
    parameter int DEPTH = MAX_ORDER_DEF * MAX_ORDER_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/leibniz_determinant_core.sv @@
// Leibniz determinant core: loads a square Q-format matrix and emits its determinant.
//
// Usage: write matrix_order (1..MAX_ORDER; 0 reads as 1, larger values as MAX_ORDER)
// through the APB port at address 0; a write also drops any partly loaded matrix,
// and s_tready stays low in the access cycle of that write.
// Stream the order*order elements on s_tdata in row-major order, one per transaction,
// at one element per cycle while s_tready is high. The last element starts the evaluation and the input
// stays blocked (s_tready low) until the result is handed to the output register.
// Evaluation walks every permutation in Lehmer-code order. Each row of a term passes
// through the store read, magnitude, low partial product, high partial product and
// renormalize-with-clamp states, and each term ends in an accumulate state; all
// reads go one after another through the one read port of the element store.
// m_tdata carries the saturated determinant, m_tuser the overflow flag. The result
// holds in the output register while m_tready is low; the next matrix loads
// meanwhile, but its result then waits in the core with the input blocked.
// Reset empties the output, sets the order to 1 and clears the element count.
module leibniz_determinant_core
    import ld_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DATA_W-1:0]  s_tdata,   // [31:0] element
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DATA_W-1:0]  m_tdata,   // [31:0] determinant
    output logic               m_tuser,   // [0] overflow
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam logic [ACC_W-1:0] PROD_LIMIT = ACC_W'(1) << (MAG_W - 1);
    localparam logic [MAG_W-1:0] LIMIT_HI   = MAG_W'(1) << (MAG_W - 1 - 32 + FRAC_BITS);
    localparam logic [ACC_W-1:0] FRAC_MASK  = (ACC_W'(1) << FRAC_BITS) - ACC_W'(1);
    localparam logic [MAG_W-1:0] ONE_FIX    = MAG_W'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sh8000_0000);

    typedef enum logic [7:0] {
        S_LOAD = 8'b0000_0001,
        S_ADDR = 8'b0000_0010,
        S_ABS  = 8'b0000_0100,
        S_MLO  = 8'b0000_1000,
        S_MHI  = 8'b0001_0000,
        S_NORM = 8'b0010_0000,
        S_ACC  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t                    state_reg;
    logic [ORDER_W-1:0]        order_reg;
    logic [CW-1:0]             load_count_reg;
    logic [IW-1:0]             row_reg;
    logic [IW-1:0]             digit_reg [MAX_ORDER];
    logic [IW-1:0]             digit_next [MAX_ORDER];
    logic [MAX_ORDER-1:0]      used_reg;
    logic [MAG_W-1:0]          term_mag_reg;
    logic                      term_neg_reg;
    logic [DATA_W-1:0]         elem_mag_reg;
    logic                      elem_neg_reg;
    logic [ACC_W-1:0]          lo_reg;
    logic [MAG_W-1:0]          hi_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      clamp_reg;
    logic                      out_valid_reg;
    logic [DATA_W-1:0]         out_det_reg;
    logic                      out_ovf_reg;

    logic [ORDER_W-1:0]        ord;
    logic [2*ORDER_W-1:0]      ord_sq;
    logic [CW-1:0]             total;
    logic [IW-1:0]             last_row;
    logic [IW-1:0]             col;
    logic [IW:0]               zcnt;
    logic                      found;
    logic                      carry;
    logic                      parity;
    logic [7:0]                addr_full;
    logic                      in_acc;
    logic                      cfg_wr;
    logic                      out_load;
    logic [DATA_W-1:0]         rd_data;
    logic [ACC_W-1:0]          hi_sh;
    logic [ACC_W-1:0]          norm_sum;
    logic                      prod_neg;
    logic                      norm_clamp;
    logic [MAG_W-1:0]          norm_mag;
    logic                      sat_hi;
    logic                      sat_lo;

    assign pready   = 1'b1;
    assign prdata   = 32'(order_reg);
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_MATRIX_ORDER);
    assign s_tready = (state_reg == S_LOAD) && !cfg_wr;
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_det_reg;
    assign m_tuser  = out_ovf_reg;

    always_comb
    begin
        priority if (order_reg == '0)
            ord = ORDER_W'(1);
        else if (int'(order_reg) > MAX_ORDER)
            ord = ORDER_W'(MAX_ORDER);
        else
            ord = order_reg;
    end

    assign ord_sq   = (2*ORDER_W)'(ord) * (2*ORDER_W)'(ord);
    assign total    = CW'(ord_sq);
    assign last_row = IW'(ord - ORDER_W'(1));

    // pick the digit-th free column for the current row
    always_comb
    begin
        col   = '0;
        zcnt  = '0;
        found = 1'b0;
        for (int c = 0; c < MAX_ORDER; c++)
        begin
            if (!used_reg[c])
            begin
                if (!found && zcnt == {1'b0, digit_reg[row_reg]})
                begin
                    col   = IW'(c);
                    found = 1'b1;
                end
                zcnt = zcnt + 1'b1;
            end
        end
    end

    assign addr_full = 8'(row_reg) * 8'(ord) + 8'(col);

    // advance the Lehmer code; carry out means every permutation is done
    always_comb
    begin
        carry  = 1'b1;
        parity = 1'b0;
        for (int r = MAX_ORDER - 1; r >= 0; r--)
        begin
            digit_next[r] = digit_reg[r];
            parity        = parity ^ digit_reg[r][0];
            if (carry && (r + 1) < int'(ord))
            begin
                if (digit_reg[r] == IW'(int'(ord) - 1 - r))
                begin
                    digit_next[r] = '0;
                end
                else
                begin
                    digit_next[r] = digit_reg[r] + IW'(1);
                    carry         = 1'b0;
                end
            end
        end
    end

    assign prod_neg   = term_neg_reg ^ elem_neg_reg;
    assign hi_sh      = ACC_W'(hi_reg) << (32 - FRAC_BITS);
    assign norm_sum   = hi_sh + (lo_reg >> FRAC_BITS)
                        + ACC_W'(prod_neg && ((lo_reg & FRAC_MASK) != '0));
    assign norm_clamp = (hi_reg > LIMIT_HI) || (norm_sum > PROD_LIMIT);
    assign norm_mag   = norm_clamp ? PROD_LIMIT[MAG_W-1:0] : norm_sum[MAG_W-1:0];

    assign sat_hi = acc_reg > SAT_MAX;
    assign sat_lo = acc_reg < SAT_MIN;

    ld_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_addr (load_count_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (state_reg == S_ADDR),
        .rd_addr (addr_full[AW-1:0]),
        .rd_data (rd_data)
    );

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc && (load_count_reg + CW'(1)) == total)
                begin
                    acc_reg      <= '0;
                    clamp_reg    <= 1'b0;
                    row_reg      <= '0;
                    used_reg     <= '0;
                    term_mag_reg <= ONE_FIX;
                    term_neg_reg <= 1'b0;
                    for (int r = 0; r < MAX_ORDER; r++)
                    begin
                        digit_reg[r] <= '0;
                    end
                end
            end
            S_ADDR:
            begin
                used_reg[col] <= 1'b1;
            end
            S_ABS:
            begin
                elem_neg_reg <= rd_data[DATA_W-1];
                elem_mag_reg <= rd_data[DATA_W-1] ? (~rd_data + DATA_W'(1)) : rd_data;
            end
            S_MLO:
            begin
                lo_reg <= ACC_W'(term_mag_reg[31:0]) * ACC_W'(elem_mag_reg);
            end
            S_MHI:
            begin
                hi_reg <= MAG_W'(term_mag_reg[MAG_W-1:32]) * MAG_W'(elem_mag_reg);
            end
            S_NORM:
            begin
                term_mag_reg <= norm_mag;
                term_neg_reg <= prod_neg && (norm_mag != '0);
                clamp_reg    <= clamp_reg | norm_clamp;
                row_reg      <= row_reg + IW'(1);
            end
            S_ACC:
            begin
                if (term_neg_reg ^ parity)
                    acc_reg <= acc_reg - $signed(ACC_W'(term_mag_reg));
                else
                    acc_reg <= acc_reg + $signed(ACC_W'(term_mag_reg));
                row_reg      <= '0;
                used_reg     <= '0;
                term_mag_reg <= ONE_FIX;
                term_neg_reg <= 1'b0;
                for (int r = 0; r < MAX_ORDER; r++)
                begin
                    digit_reg[r] <= digit_next[r];
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    priority if (sat_hi)
                        out_det_reg <= 32'h7FFF_FFFF;
                    else if (sat_lo)
                        out_det_reg <= 32'h8000_0000;
                    else
                        out_det_reg <= acc_reg[DATA_W-1:0];
                    out_ovf_reg <= clamp_reg | sat_hi | sat_lo;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            order_reg      <= ORDER_W'(1);
            load_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            // s_tready is low during a write, so the count has one source per cycle
            if (cfg_wr)
            begin
                order_reg      <= pwdata[ORDER_W-1:0];
                load_count_reg <= '0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if ((load_count_reg + CW'(1)) == total)
                        begin
                            load_count_reg <= '0;
                            state_reg      <= S_ADDR;
                        end
                        else
                        begin
                            load_count_reg <= load_count_reg + CW'(1);
                        end
                    end
                end
                S_ADDR: state_reg <= S_ABS;
                S_ABS:  state_reg <= S_MLO;
                S_MLO:  state_reg <= S_MHI;
                S_MHI:  state_reg <= S_NORM;
                S_NORM:
                begin
                    state_reg <= (row_reg == last_row) ? S_ACC : S_ADDR;
                end
                S_ACC:
                begin
                    state_reg <= carry ? S_OUT : S_ADDR;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule
